>>> rtl/sdc_pkg.sv
// ----------------------------------------------------------------------------
// Sector disk controller package
// Shared codes, controller states and the command/status bundles that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package sdc_pkg;

  // Bus item codes
  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_REG_READ  = 3'd1,
    CMD_REG_WRITE = 3'd2,
    CMD_MEM_DATA  = 3'd3,
    CMD_IRQ_CLEAR = 3'd4
  } cmd_e;

  // Register map
  typedef enum logic [1:0] {
    REG_CMD    = 2'd0,
    REG_SECTOR = 2'd1,
    REG_BUFFER = 2'd2,
    REG_STATUS = 2'd3
  } reg_e;

  // Disk command register values that move data
  localparam logic [31:0] DISK_READ  = 32'd1;
  localparam logic [31:0] DISK_WRITE = 32'd2;

  localparam logic [15:0] BUSY_CYCLES_RESET = 16'd1025;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COUNT,
    ST_XFER,
    ST_AWAIT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic clear_step;
    logic wr_cmd;
    logic wr_sector;
    logic wr_buffer;
    logic start;
    logic count_dec;
    logic idx_clr;
    logic idx_inc;
    logic store_rd;
    logic store_wr;
    logic req_wr;
    logic req_rd;
    logic irq_set;
    logic irq_clr;
    logic reg_read;
    logic busy_now;
    logic busy_after;
  } ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_done;
    logic res_hold;
    logic count_gt1;
    logic cmd_read;
    logic cmd_rw;
    logic sector_ok;
    logic xfer_end;
    logic wval_nz;
  } stat_t;

endpackage

>>> rtl/sdc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sdc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/sdc_ctrl.sv
// ----------------------------------------------------------------------------
// Sector disk controller state machine
// Decodes bus items against the disk state and issues datapath commands.
// ----------------------------------------------------------------------------
module sdc_ctrl
  import sdc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [2:0] command,
  input  logic [1:0] reg_index,
  input  stat_t      stat,
  output logic       in_stall,
  output ctrl_t      ctrl
);

  state_e state;
  state_e state_next;
  logic   accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    ctrl            = '0;
    state_next      = state;
    in_stall        = (state == ST_CLEAR) || stat.res_hold;
    accept          = in_valid && !in_stall;
    ctrl.accept     = accept;
    ctrl.clear_step = (state == ST_CLEAR);
    ctrl.busy_now   = state inside {ST_COUNT, ST_XFER, ST_AWAIT};

    if (state == ST_CLEAR) begin
      if (stat.clear_done) begin
        state_next = ST_IDLE;
      end
    end else if (accept) begin
      case (command)
        CMD_TICK: begin
          case (state)
            ST_COUNT: begin
              if (stat.count_gt1) begin
                ctrl.count_dec = 1'b1;
              end else if (stat.cmd_rw) begin
                ctrl.idx_clr = 1'b1;
                if (stat.sector_ok) begin
                  state_next = ST_XFER;
                end else begin
                  ctrl.irq_set = 1'b1;
                  state_next   = ST_IDLE;
                end
              end else begin
                state_next = ST_IDLE;
              end
            end
            ST_XFER: begin
              if (stat.xfer_end) begin
                ctrl.irq_set = 1'b1;
                ctrl.idx_clr = 1'b1;
                state_next   = ST_IDLE;
              end else if (stat.cmd_read) begin
                ctrl.req_wr   = 1'b1;
                ctrl.store_rd = 1'b1;
                ctrl.idx_inc  = 1'b1;
              end else begin
                ctrl.req_rd = 1'b1;
                state_next  = ST_AWAIT;
              end
            end
            default: ;
          endcase
        end
        CMD_REG_READ: begin
          ctrl.reg_read = 1'b1;
        end
        CMD_REG_WRITE: begin
          if (state == ST_IDLE) begin
            case (reg_index)
              REG_CMD: begin
                ctrl.wr_cmd = 1'b1;
                if (stat.wval_nz) begin
                  ctrl.start = 1'b1;
                  state_next = ST_COUNT;
                end
              end
              REG_SECTOR: ctrl.wr_sector = 1'b1;
              REG_BUFFER: ctrl.wr_buffer = 1'b1;
              default: ;
            endcase
          end
        end
        CMD_MEM_DATA: begin
          if (state == ST_AWAIT) begin
            ctrl.store_wr = 1'b1;
            ctrl.idx_inc  = 1'b1;
            state_next    = ST_XFER;
          end
        end
        CMD_IRQ_CLEAR: begin
          ctrl.irq_clr = 1'b1;
        end
        default: ;
      endcase
    end

    ctrl.busy_after = state_next inside {ST_COUNT, ST_XFER, ST_AWAIT};
  end

endmodule

>>> rtl/sdc_datapath.sv
// ----------------------------------------------------------------------------
// Sector disk controller datapath
// Registers, sector store, address arithmetic and the two-deep result stage.
// ----------------------------------------------------------------------------
module sdc_datapath
  import sdc_pkg::*;
#(
  parameter int SECTOR_COUNT = 128,
  parameter int SECTOR_WORDS = 128,
  parameter int MEM_WORDS    = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  ctrl_t       ctrl,
  output stat_t       stat,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic [1:0]  reg_index,
  input  logic [31:0] write_value,
  input  logic [31:0] mem_read_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] read_data,
  output logic        bad_index,
  output logic        mem_write_valid,
  output logic        mem_read_valid,
  output logic [11:0] mem_addr,
  output logic [31:0] mem_write_word,
  output logic        busy_res,
  output logic        irq
);

  localparam int STORE_WORDS = SECTOR_COUNT * SECTOR_WORDS;
  localparam int AW = $clog2(STORE_WORDS > 1 ? STORE_WORDS : 2);
  localparam int SB = $clog2(SECTOR_COUNT > 1 ? SECTOR_COUNT : 2);
  localparam int IW = $clog2(SECTOR_WORDS + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(STORE_WORDS - 1);

  logic [15:0]   busy_cycles;
  logic [31:0]   cmd_reg;
  logic [31:0]   sector_reg;
  logic [31:0]   buffer_reg;
  logic [15:0]   countdown;
  logic [IW-1:0] word_index;
  logic          irq_pending;
  logic          irq_next;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] slot;
  logic [32:0]   addr_sum;
  logic          addr_neg;
  logic          addr_high;
  logic          idx_end;
  logic [31:0]   reg_mux;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [31:0]   ram_rdata;

  // Result stage ahead of the output register
  logic          res_valid;
  logic          res_move;
  logic [31:0]   res_read_data;
  logic          res_mem_wr;
  logic          res_mem_rd;
  logic [11:0]   res_addr;
  logic          res_busy;
  logic          res_irq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_cycles <= BUSY_CYCLES_RESET;
    end else if (cfg_wr_en) begin
      busy_cycles <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_reg     <= '0;
      sector_reg  <= '0;
      buffer_reg  <= '0;
      countdown   <= '0;
      word_index  <= '0;
      irq_pending <= 1'b0;
      clr_addr    <= '0;
    end else begin
      if (ctrl.wr_cmd) begin
        cmd_reg <= write_value;
      end
      if (ctrl.wr_sector) begin
        sector_reg <= write_value;
      end
      if (ctrl.wr_buffer) begin
        buffer_reg <= write_value;
      end
      if (ctrl.start) begin
        countdown <= busy_cycles;
      end else if (ctrl.count_dec) begin
        countdown <= countdown - 16'd1;
      end
      if (ctrl.start || ctrl.idx_clr) begin
        word_index <= '0;
      end else if (ctrl.idx_inc) begin
        word_index <= word_index + IW'(1);
      end
      irq_pending <= irq_next;
      if (ctrl.clear_step) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  assign irq_next = ctrl.irq_set ? 1'b1 : (ctrl.irq_clr ? 1'b0 : irq_pending);

  // Sector is checked before the transfer starts, so the slot stays in range
  assign slot = AW'(sector_reg[SB-1:0]) * AW'(SECTOR_WORDS) + AW'(word_index);

  assign addr_sum  = {buffer_reg[31], buffer_reg} + {{(33 - IW){1'b0}}, word_index};
  assign addr_neg  = addr_sum[32];
  assign addr_high = !addr_neg && (addr_sum[31:0] >= 32'(MEM_WORDS));
  assign idx_end   = word_index >= IW'(SECTOR_WORDS);

  assign stat.clear_done = (clr_addr == LAST_SLOT);
  assign stat.res_hold   = res_valid && !res_move;
  assign stat.count_gt1  = countdown > 16'd1;
  assign stat.cmd_read   = (cmd_reg == DISK_READ);
  assign stat.cmd_rw     = (cmd_reg == DISK_READ) || (cmd_reg == DISK_WRITE);
  assign stat.sector_ok  = !sector_reg[31] && (sector_reg < 32'(SECTOR_COUNT));
  assign stat.xfer_end   = idx_end || addr_neg || addr_high;
  assign stat.wval_nz    = (write_value != 32'd0);

  always_comb begin
    case (reg_index)
      REG_CMD:    reg_mux = cmd_reg;
      REG_SECTOR: reg_mux = sector_reg;
      REG_BUFFER: reg_mux = buffer_reg;
      default:    reg_mux = {31'd0, ctrl.busy_now};
    endcase
  end

  assign ram_we    = ctrl.clear_step || ctrl.store_wr;
  assign ram_waddr = ctrl.clear_step ? clr_addr : slot;
  assign ram_wdata = ctrl.clear_step ? 32'd0 : mem_read_word;

  sdc_ram #(
    .WIDTH (32),
    .DEPTH (STORE_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ctrl.store_rd),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  assign res_move = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.accept) begin
        res_valid <= 1'b1;
      end else if (res_move) begin
        res_valid <= 1'b0;
      end
      if (res_move) begin
        out_valid <= res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      res_read_data <= ctrl.reg_read ? reg_mux : 32'd0;
      res_mem_wr    <= ctrl.req_wr;
      res_mem_rd    <= ctrl.req_rd;
      res_addr      <= (ctrl.req_wr || ctrl.req_rd) ? addr_sum[11:0] : 12'd0;
      res_busy      <= ctrl.busy_after;
      res_irq       <= irq_next;
    end
    // Store read data is registered at accept and holds until the next read
    if (res_move && res_valid) begin
      read_data       <= res_read_data;
      bad_index       <= 1'b0;
      mem_write_valid <= res_mem_wr;
      mem_read_valid  <= res_mem_rd;
      mem_addr        <= res_addr;
      mem_write_word  <= res_mem_wr ? ram_rdata : 32'd0;
      busy_res        <= res_busy;
      irq             <= res_irq;
    end
  end

endmodule

>>> rtl/sector_disk_dma_controller.sv
// ----------------------------------------------------------------------------
// Sector disk DMA controller
// Sector store with command/sector/buffer/status registers and a word-serial
// transfer path to main memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one bus item per accept: a
//   tick, a register read or write, a main memory read answer, or an
//   interrupt clear. Every item yields exactly one result item on the output
//   channel (out_valid/out_stall) with read data, any memory request, and
//   busy and interrupt status after that item.
//   Throughput is one item per cycle while in_stall is low; each item does
//   at most one sector store access. A result passes through a result stage
//   and the output register after its item is accepted.
//   When the receiver stalls, the output register holds and the result stage
//   still takes one more item; after that in_stall rises until out_stall
//   drops.
//   After reset the sector store is cleared one word per cycle, all
//   SECTOR_COUNT * SECTOR_WORDS words (16384 by default); in_stall is high
//   throughout. The busy_cycles register (cfg_wr_en/cfg_wr_data) resets to
//   1025 and may be written while the block is idle.
// ----------------------------------------------------------------------------
module sector_disk_dma_controller
  import sdc_pkg::*;
#(
  parameter int SECTOR_COUNT = 128,
  parameter int SECTOR_WORDS = 128,
  parameter int MEM_WORDS    = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  command,
  input  logic [1:0]  reg_index,
  input  logic [31:0] write_value,
  input  logic [31:0] mem_read_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] read_data,
  output logic        bad_index,
  output logic        mem_write_valid,
  output logic        mem_read_valid,
  output logic [11:0] mem_addr,
  output logic [31:0] mem_write_word,
  output logic        busy_res,
  output logic        irq
);

  ctrl_t ctrl;
  stat_t stat;

  sdc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .command   (command),
    .reg_index (reg_index),
    .stat      (stat),
    .in_stall  (in_stall),
    .ctrl      (ctrl)
  );

  sdc_datapath #(
    .SECTOR_COUNT (SECTOR_COUNT),
    .SECTOR_WORDS (SECTOR_WORDS),
    .MEM_WORDS    (MEM_WORDS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (ctrl),
    .stat            (stat),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .reg_index       (reg_index),
    .write_value     (write_value),
    .mem_read_word   (mem_read_word),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .read_data       (read_data),
    .bad_index       (bad_index),
    .mem_write_valid (mem_write_valid),
    .mem_read_valid  (mem_read_valid),
    .mem_addr        (mem_addr),
    .mem_write_word  (mem_write_word),
    .busy_res        (busy_res),
    .irq             (irq)
  );

  // Store clear keeps the input side closed right after reset
  assert property (@(posedge clk) $past(rst) |-> in_stall)
    else $error("input accepted during store clear");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(mem_write_valid && mem_read_valid))
    else $error("memory read and write requested by one item");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (mem_write_valid || mem_read_valid)) |-> busy_res)
    else $error("memory request while not busy");

  assert property (@(posedge clk) disable iff (rst)
    (ctrl.irq_set && ctrl.accept) |=> !ctrl.busy_now)
    else $error("interrupt raised without leaving busy");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sector disk DMA controller testbench
// Drives bus items through the valid/stall input channel and checks every
// result item against a cycle-free model of the registers, the countdown,
// the word-serial transfer and the sector store. Runs directed cases, then
// randomized disk jobs under several idling mixes, a long receiver hold-off
// and the largest start delay.
// ----------------------------------------------------------------------------
module tb_top;
  import sdc_pkg::*;

  localparam int SECTOR_COUNT     = 128;
  localparam int SECTOR_WORDS     = 128;
  localparam int MEM_WORDS        = 4096;
  localparam int STORE_WORDS      = SECTOR_COUNT * SECTOR_WORDS;
  localparam int WATCHDOG_LIMIT   = 60000;
  localparam int HOLD_CYCLES      = 300;
  localparam int MAX_GAP          = 30;
  localparam int DRAIN_PAD        = 4;
  localparam int MAX_REPORTS      = 60;
  localparam int ITEMS_PER_PHASE  = 260;
  localparam int PRESSURE_ITEMS   = 60;
  localparam int START_TICKS      = 8;

  localparam logic [2:0]  CMD_UNUSED_FIRST = 3'd5;
  localparam logic [2:0]  CMD_UNUSED_LAST  = 3'd7;
  localparam logic [31:0] DISK_NONE        = 32'd0;

  typedef struct packed {
    logic [31:0] read_data;
    logic        bad_index;
    logic        mem_write_valid;
    logic        mem_read_valid;
    logic [11:0] mem_addr;
    logic [31:0] mem_write_word;
    logic        busy_res;
    logic        irq;
  } disk_result_t;

  class disk_predictor;
    logic [15:0]  start_delay;
    logic [31:0]  cmd_word;
    logic [31:0]  sector_word;
    logic [31:0]  buffer_word;
    bit           busy;
    bit           moving;
    bit           waiting_word;
    bit           irq_level;
    int unsigned  ticks_left;
    int           word_pos;
    bit [31:0]    store_words [STORE_WORDS];
    disk_result_t due_results [$];
    int           errors;

    function new();
      start_delay  = BUSY_CYCLES_RESET;
      cmd_word     = '0;
      sector_word  = '0;
      buffer_word  = '0;
      busy         = 1'b0;
      moving       = 1'b0;
      waiting_word = 1'b0;
      irq_level    = 1'b0;
      ticks_left   = 0;
      word_pos     = 0;
      errors       = 0;
    endfunction

    function bit sector_in_range();
      int s;
      s = sector_word;
      return s >= 0 && s < SECTOR_COUNT;
    endfunction

    function int store_slot();
      longint p;
      p = longint'(sector_word) * SECTOR_WORDS + word_pos;
      return int'(p % STORE_WORDS);
    endfunction

    function void wrap_up();
      irq_level    = 1'b1;
      busy         = 1'b0;
      moving       = 1'b0;
      waiting_word = 1'b0;
      word_pos     = 0;
    endfunction

    function void advance_tick(inout disk_result_t r);
      int     base;
      longint addr;
      if (!busy) return;
      if (!moving) begin
        if (ticks_left > 1) begin
          ticks_left--;
          return;
        end
        ticks_left = 0;
        if (cmd_word == DISK_READ || cmd_word == DISK_WRITE) begin
          if (sector_in_range()) begin
            moving       = 1'b1;
            word_pos     = 0;
            waiting_word = 1'b0;
          end else begin
            wrap_up();
          end
        end else begin
          busy = 1'b0;
        end
        return;
      end
      // hold until the memory word arrives
      if (waiting_word) return;
      base = buffer_word;
      addr = longint'(base) + word_pos;
      if (word_pos >= SECTOR_WORDS || addr < 0 || addr >= MEM_WORDS) begin
        wrap_up();
        return;
      end
      r.mem_addr = addr[11:0];
      if (cmd_word == DISK_READ) begin
        r.mem_write_valid = 1'b1;
        r.mem_write_word  = store_words[store_slot()];
        word_pos++;
      end else begin
        r.mem_read_valid = 1'b1;
        waiting_word     = 1'b1;
      end
    endfunction

    function void note_item(logic [2:0] code, logic [1:0] sel, logic [31:0] wv,
                            logic [31:0] mw);
      disk_result_t r;
      r = '0;
      case (code)
        CMD_TICK: advance_tick(r);
        CMD_REG_READ: begin
          case (sel)
            REG_CMD:    r.read_data = cmd_word;
            REG_SECTOR: r.read_data = sector_word;
            REG_BUFFER: r.read_data = buffer_word;
            default:    r.read_data = {31'b0, busy};
          endcase
        end
        CMD_REG_WRITE: begin
          if (!busy) begin
            case (sel)
              REG_CMD: begin
                cmd_word = wv;
                if (wv != DISK_NONE) begin
                  busy         = 1'b1;
                  ticks_left   = start_delay;
                  moving       = 1'b0;
                  waiting_word = 1'b0;
                  word_pos     = 0;
                end
              end
              REG_SECTOR: sector_word = wv;
              REG_BUFFER: buffer_word = wv;
              default: ;
            endcase
          end
        end
        CMD_MEM_DATA: begin
          if (busy && moving && waiting_word) begin
            store_words[store_slot()] = mw;
            word_pos++;
            waiting_word = 1'b0;
          end
        end
        CMD_IRQ_CLEAR: irq_level = 1'b0;
        default: ;
      endcase
      r.busy_res = busy;
      r.irq      = irq_level;
      due_results.push_back(r);
    endfunction

    function void field_check(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        if (errors < MAX_REPORTS)
          $display("%0t: %s expected %h actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_item(disk_result_t got);
      disk_result_t want;
      if (due_results.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("%0t: result with no item outstanding, expected none actual %h",
                   $time, got);
        errors++;
        return;
      end
      want = due_results.pop_front();
      field_check("read_data", want.read_data, got.read_data);
      field_check("bad_index", want.bad_index, got.bad_index);
      field_check("mem_write_valid", want.mem_write_valid, got.mem_write_valid);
      field_check("mem_read_valid", want.mem_read_valid, got.mem_read_valid);
      field_check("mem_addr", want.mem_addr, got.mem_addr);
      field_check("mem_write_word", want.mem_write_word, got.mem_write_word);
      field_check("busy_res", want.busy_res, got.busy_res);
      field_check("irq", want.irq, got.irq);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  command;
  logic [1:0]  reg_index;
  logic [31:0] write_value;
  logic [31:0] mem_read_word;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] read_data;
  logic        bad_index;
  logic        mem_write_valid;
  logic        mem_read_valid;
  logic [11:0] mem_addr;
  logic [31:0] mem_write_word;
  logic        busy_res;
  logic        irq;

  disk_predictor board = new();
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int item_count    = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  bit hold_req      = 1'b0;

  sector_disk_dma_controller dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .command         (command),
    .reg_index       (reg_index),
    .write_value     (write_value),
    .mem_read_word   (mem_read_word),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .read_data       (read_data),
    .bad_index       (bad_index),
    .mem_write_valid (mem_write_valid),
    .mem_read_valid  (mem_read_valid),
    .mem_addr        (mem_addr),
    .mem_write_word  (mem_write_word),
    .busy_res        (busy_res),
    .irq             (irq)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Result side: check accepted items, then pick the next stall
  always @(posedge clk) begin : result_side
    disk_result_t seen;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        seen = {read_data, bad_index, mem_write_valid, mem_read_valid, mem_addr,
                mem_write_word, busy_res, irq};
        board.check_item(seen);
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input logic [2:0] code, input logic [1:0] sel,
                           input logic [31:0] wv, input logic [31:0] mw);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    command       <= code;
    reg_index     <= sel;
    write_value   <= wv;
    mem_read_word <= mw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_item(code, sel, wv, mw);
    item_count++;
  endtask

  task automatic write_reg(input logic [1:0] sel, input logic [31:0] value);
    send_item(CMD_REG_WRITE, sel, value, pick_word());
  endtask

  task automatic random_noise();
    case ($urandom_range(5))
      0: send_item(CMD_REG_READ, 2'($urandom_range(3)), pick_word(), pick_word());
      1: send_item(CMD_REG_WRITE, 2'($urandom_range(3)), pick_word(), pick_word());
      2: send_item(CMD_IRQ_CLEAR, 2'($urandom_range(3)), pick_word(), pick_word());
      3: send_item(3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST)),
                   2'($urandom_range(3)), pick_word(), pick_word());
      4: send_item(CMD_MEM_DATA, 2'($urandom_range(3)), pick_word(), pick_word());
      default: send_item(CMD_TICK, 2'($urandom_range(3)), pick_word(), pick_word());
    endcase
  endtask

  // Tick until the job is done, answering memory reads most of the time
  task automatic complete_job(input int noise_pct);
    while (board.busy) begin
      if (board.waiting_word && $urandom_range(99) < 70)
        send_item(CMD_MEM_DATA, 2'($urandom_range(3)), pick_word(), pick_word());
      else if ($urandom_range(99) < noise_pct)
        random_noise();
      else
        send_item(CMD_TICK, 2'($urandom_range(3)), pick_word(), pick_word());
    end
  endtask

  task automatic drive_job(input logic [31:0] sec, input logic [31:0] addr,
                           input logic [31:0] disk_cmd);
    write_reg(REG_SECTOR, sec);
    write_reg(REG_BUFFER, addr);
    write_reg(REG_CMD, disk_cmd);
    complete_job(0);
  endtask

  task automatic random_job();
    logic [31:0] sec;
    logic [31:0] addr;
    logic [31:0] disk_cmd;
    int roll;
    roll = $urandom_range(99);
    // favor a few sectors so that written data gets read back
    if (roll < 55)      sec = $urandom_range(3);
    else if (roll < 75) sec = $urandom_range(SECTOR_COUNT - 1);
    else if (roll < 80) sec = SECTOR_COUNT - 1;
    else if (roll < 88) sec = $urandom;
    else if (roll < 94) sec = SECTOR_COUNT + $urandom_range(200);
    else                sec = 32'h8000_0000 | $urandom;
    roll = $urandom_range(99);
    // mostly short transfers that run into the end of memory
    if (roll < 58)      addr = MEM_WORDS - $urandom_range(12, 1);
    else if (roll < 64) addr = $urandom_range(MEM_WORDS - SECTOR_WORDS);
    else if (roll < 74) addr = MEM_WORDS - $urandom_range(140, 13);
    else if (roll < 82) addr = $urandom;
    else if (roll < 90) addr = -$urandom_range(8, 1);
    else                addr = MEM_WORDS + $urandom_range(4);
    roll = $urandom_range(99);
    if (roll < 45)      disk_cmd = DISK_READ;
    else if (roll < 88) disk_cmd = DISK_WRITE;
    else if (roll < 93) disk_cmd = DISK_NONE;
    else                disk_cmd = $urandom | 32'd1;
    if ($urandom_range(99) < 90) write_reg(REG_SECTOR, sec);
    if ($urandom_range(99) < 90) write_reg(REG_BUFFER, addr);
    if ($urandom_range(99) < 15) random_noise();
    write_reg(REG_CMD, disk_cmd);
    complete_job(12);
    if ($urandom_range(99) < 70)
      send_item(CMD_IRQ_CLEAR, 2'($urandom_range(3)), pick_word(), pick_word());
    if ($urandom_range(99) < 20)
      send_item(CMD_REG_READ, 2'($urandom_range(3)), pick_word(), pick_word());
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic program_delay(input logic [15:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    board.start_delay = value;
  endtask

  initial begin : stimulus
    int k;
    int stop_at;
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_valid      = 1'b0;
    command       = CMD_TICK;
    reg_index     = REG_CMD;
    write_value   = '0;
    mem_read_word = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // zero start delay behaves as one tick
    program_delay(16'd0);
    for (k = REG_CMD; k <= REG_STATUS; k++)
      send_item(CMD_REG_READ, k[1:0], pick_word(), pick_word());
    write_reg(REG_CMD, DISK_NONE);
    write_reg(REG_STATUS, 32'hFFFF_FFFF);
    send_item(CMD_MEM_DATA, REG_SECTOR, 32'h7FFF_FFFF, 32'h8000_0000);
    for (k = CMD_UNUSED_FIRST; k <= CMD_UNUSED_LAST; k++)
      send_item(k[2:0], REG_BUFFER, 32'h8000_0000, 32'h7FFF_FFFF);
    drive_job(32'hFFFF_FFFF, 32'd0, DISK_WRITE);
    send_item(CMD_REG_READ, REG_STATUS, '0, '0);
    send_item(CMD_IRQ_CLEAR, REG_STATUS, '0, '0);
    drive_job(SECTOR_COUNT, 32'd0, DISK_READ);
    drive_job(SECTOR_COUNT - 1, MEM_WORDS - 4, DISK_WRITE);
    drive_job(SECTOR_COUNT - 1, MEM_WORDS - 4, DISK_READ);
    drive_job(32'd1, 32'hFFFF_FFFF, DISK_READ);
    drive_job(32'd0, 32'h7FFF_FFFF, DISK_WRITE);
    drive_job(32'd0, 32'd0, 32'hFFFF_FFFF);
    // writes while busy are dropped
    write_reg(REG_CMD, DISK_READ);
    write_reg(REG_SECTOR, 32'd9);
    write_reg(REG_BUFFER, 32'd11);
    write_reg(REG_CMD, DISK_WRITE);
    complete_job(0);
    send_item(CMD_IRQ_CLEAR, REG_CMD, '1, '1);
    wait_drained();

    for (k = 0; k < 4; k++) begin
      case (k)
        0: begin program_delay(16'd1); send_idle_pct = 0;  stall_pct = 0;  end
        1: begin program_delay(16'd3); send_idle_pct = 73; stall_pct = 0;  end
        2: begin program_delay(16'd0); send_idle_pct = 0;  stall_pct = 73; end
        default: begin program_delay(16'd7); send_idle_pct = 21; stall_pct = 21; end
      endcase
      stop_at = item_count + ITEMS_PER_PHASE;
      while (item_count < stop_at) random_job();
      wait_drained();
    end

    // long receiver hold-off while items keep coming
    program_delay(16'd2);
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 1'b1;
    stop_at = item_count + PRESSURE_ITEMS;
    while (item_count < stop_at) random_job();
    wait_drained();

    // start a job on the largest delay and tick a few times; it stays busy
    program_delay(16'hFFFF);
    write_reg(REG_SECTOR, 32'd5);
    write_reg(REG_BUFFER, MEM_WORDS - 6);
    write_reg(REG_CMD, DISK_READ);
    for (k = 0; k < START_TICKS; k++)
      send_item(CMD_TICK, REG_CMD, pick_word(), pick_word());
    send_item(CMD_REG_READ, REG_STATUS, '0, '0);
    wait_drained();

    repeat (8) @(posedge clk);
    if (board.errors == 0 && board.due_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
